FILE: rtl/mceb_pkg.sv
// ----------------------------------------------------------------------------
// Monochrome color expansion blit: shared types and constants
// Register indexes, write modes, pixel actions and fixed field widths.
// ----------------------------------------------------------------------------
package mceb_pkg;

    localparam int MASK_BITS  = 16;
    localparam int BIT_IDX_W  = 4;
    localparam int COLOR_W    = 16;
    localparam int DIM_REG_W  = 13;
    localparam int SKIP_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        MODE_REPLACE     = 2'd0,
        MODE_TRANSPARENT = 2'd1,
        MODE_XOR         = 2'd2,
        MODE_REV_TRANS   = 2'd3
    } t_write_mode;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_INVERT = 2'd1,
        ACT_KEEP   = 2'd2
    } t_action;

    localparam logic [CFG_IDX_W-1:0] REG_WRITE_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_OFFSET = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DST_SKIP   = 3'd6;

    localparam logic [COLOR_W-1:0]   FG_RESET  = 16'hffff;
    localparam logic [COLOR_W-1:0]   BG_RESET  = 16'h0000;
    localparam logic [DIM_REG_W-1:0] DIM_RESET = 13'd1;

endpackage

FILE: rtl/mono_color_expand_blit_core.sv
// ----------------------------------------------------------------------------
// Monochrome color expansion blit core
// Expands 16-bit mask words into destination pixel offsets and actions.
// ----------------------------------------------------------------------------
// Usage:
// Mask words enter on the input channel (i_in_valid / o_in_ready), MSB first.
// Each word yields one to sixteen pixels on the output channel (o_out_valid /
// i_out_ready), one pixel per cycle while the receiver does not stall: sixteen
// for a full word, fewer for the first word of a row with a bit offset or the
// last word of a row.
// The first pixel of a word goes from the held word into the output register. The
// next word is taken in the same cycle the last pixel of the current word is
// loaded into the output register, so words stream without gaps.
// The pixel rate is set by the single output register, which takes one pixel
// per cycle from the held word while the receiver does not stall.
// When the receiver stalls, the output register holds its pixel and no state
// advances; the held word waits and further input waits behind it.
// Reset empties both registers and returns the area position to its start;
// the configuration registers take their reset values. Configuration is
// written through i_cfg_we / i_cfg_index / i_cfg_data while the block is idle.
// ----------------------------------------------------------------------------
module mono_color_expand_blit_core #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int ADDR_BITS  = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mceb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mceb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [15:0]                         i_mask_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [ADDR_BITS-1:0]                o_pixel_offset,
    output logic [15:0]                         o_pixel_value,
    output logic [1:0]                          o_pixel_action,
    output logic                                o_word_last,
    output logic                                o_area_done
);
    import mceb_pkg::*;

    localparam int WD = $clog2(MAX_WIDTH + 1);
    localparam int HD = $clog2(MAX_HEIGHT + 1);

    // Configuration registers.
    t_write_mode            r_write_mode;
    logic [COLOR_W-1:0]     r_fg_color;
    logic [COLOR_W-1:0]     r_bg_color;
    logic [DIM_REG_W-1:0]   r_area_width;
    logic [DIM_REG_W-1:0]   r_area_height;
    logic [BIT_IDX_W-1:0]   r_src_offset;
    logic [SKIP_W-1:0]      r_dst_skip;

    // Held word and area position.
    logic                   r_word_valid;
    logic [MASK_BITS-1:0]   r_word;
    logic [BIT_IDX_W-1:0]   r_bit;
    logic                   r_first;
    logic [HD-1:0]          r_row;
    logic [WD-1:0]          r_col;
    logic [ADDR_BITS-1:0]   r_cursor;

    // Output register.
    logic                   r_out_valid;
    logic [ADDR_BITS-1:0]   r_pix_offset;
    logic [COLOR_W-1:0]     r_pix_value;
    t_action                r_pix_action;
    logic                   r_pix_last;
    logic                   r_pix_done;

    logic [31:0]            w_full;
    logic [31:0]            h_full;
    logic [WD-1:0]          area_w;
    logic [HD-1:0]          area_h;
    logic                   out_free;
    logic                   gen;
    logic                   word_done;
    logic                   in_fire;
    logic                   restart;
    logic [HD-1:0]          e_row;
    logic [WD-1:0]          e_col;
    logic [ADDR_BITS-1:0]   e_cursor;
    logic [BIT_IDX_W-1:0]   start_bit;
    logic [BIT_IDX_W-1:0]   bit_idx;
    logic                   src_bit;
    logic [WD-1:0]          col_inc;
    logic [HD-1:0]          row_inc;
    logic                   row_end;
    logic                   area_end;
    logic                   pix_last;
    logic [ADDR_BITS-1:0]   cursor_inc;
    logic [HD-1:0]          n_row;
    logic [WD-1:0]          n_col;
    logic [ADDR_BITS-1:0]   n_cursor;
    logic [COLOR_W-1:0]     mode_value;
    t_action                mode_action;

    // Zero dimensions count as one; large ones saturate at the maximum.
    always_comb begin
        w_full = 32'(r_area_width);
        h_full = 32'(r_area_height);
        if (w_full == 32'd0) begin
            w_full = 32'd1;
        end else if (w_full > 32'(MAX_WIDTH)) begin
            w_full = 32'(MAX_WIDTH);
        end
        if (h_full == 32'd0) begin
            h_full = 32'd1;
        end else if (h_full > 32'(MAX_HEIGHT)) begin
            h_full = 32'(MAX_HEIGHT);
        end
    end
    assign area_w = w_full[WD-1:0];
    assign area_h = h_full[HD-1:0];

    assign out_free   = !r_out_valid || i_out_ready;
    assign gen        = r_word_valid && out_free;
    assign word_done  = gen && pix_last;
    assign o_in_ready = !r_word_valid || word_done;
    assign in_fire    = i_in_valid && o_in_ready;

    // A word that finds the position outside the area starts a fresh area.
    assign restart  = r_first && ((r_row >= area_h) || (r_col >= area_w));
    assign e_row    = restart ? '0 : r_row;
    assign e_col    = restart ? '0 : r_col;
    assign e_cursor = restart ? '0 : r_cursor;

    assign start_bit = (e_col == '0) ? r_src_offset : '0;
    assign bit_idx   = r_first ? (BIT_IDX_W'(MASK_BITS - 1) - start_bit) : r_bit;
    assign src_bit   = r_word[bit_idx];

    assign col_inc    = e_col + WD'(1);
    assign row_inc    = e_row + HD'(1);
    assign row_end    = (col_inc == area_w);
    assign area_end   = row_end && (row_inc == area_h);
    assign pix_last   = (bit_idx == '0) || row_end;
    assign cursor_inc = e_cursor + ADDR_BITS'(1);

    always_comb begin
        n_row    = e_row;
        n_col    = col_inc;
        n_cursor = cursor_inc;
        if (area_end) begin
            n_row    = '0;
            n_col    = '0;
            n_cursor = '0;
        end else if (row_end) begin
            n_row    = row_inc;
            n_col    = '0;
            n_cursor = cursor_inc + ADDR_BITS'(r_dst_skip);
        end
    end

    mceb_pixel_mode u_pixel_mode (
        .i_mode   (r_write_mode),
        .i_bit    (src_bit),
        .i_fg     (r_fg_color),
        .i_bg     (r_bg_color),
        .o_value  (mode_value),
        .o_action (mode_action)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_mode  <= MODE_REPLACE;
            r_fg_color    <= FG_RESET;
            r_bg_color    <= BG_RESET;
            r_area_width  <= DIM_RESET;
            r_area_height <= DIM_RESET;
            r_src_offset  <= '0;
            r_dst_skip    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WRITE_MODE:  r_write_mode  <= t_write_mode'(i_cfg_data[1:0]);
                REG_FG_COLOR:    r_fg_color    <= i_cfg_data[COLOR_W-1:0];
                REG_BG_COLOR:    r_bg_color    <= i_cfg_data[COLOR_W-1:0];
                REG_AREA_WIDTH:  r_area_width  <= i_cfg_data[DIM_REG_W-1:0];
                REG_AREA_HEIGHT: r_area_height <= i_cfg_data[DIM_REG_W-1:0];
                REG_SRC_OFFSET:  r_src_offset  <= i_cfg_data[BIT_IDX_W-1:0];
                REG_DST_SKIP:    r_dst_skip    <= i_cfg_data[SKIP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_valid <= 1'b0;
            r_first      <= 1'b0;
            r_bit        <= '0;
            r_row        <= '0;
            r_col        <= '0;
            r_cursor     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (gen) begin
                r_row       <= n_row;
                r_col       <= n_col;
                r_cursor    <= n_cursor;
                r_bit       <= bit_idx - BIT_IDX_W'(1);
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_fire) begin
                r_word_valid <= 1'b1;
                r_first      <= 1'b1;
            end else begin
                if (word_done) begin
                    r_word_valid <= 1'b0;
                end
                if (gen) begin
                    r_first <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_word <= i_mask_word;
        end
        if (gen) begin
            r_pix_offset <= e_cursor;
            r_pix_value  <= mode_value;
            r_pix_action <= mode_action;
            r_pix_last   <= pix_last;
            r_pix_done   <= area_end;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_offset = r_pix_offset;
    assign o_pixel_value  = r_pix_value;
    assign o_pixel_action = r_pix_action;
    assign o_word_last    = r_pix_last;
    assign o_area_done    = r_pix_done;

    // The final pixel of an area always closes its word.
    a_done_ends_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_area_done) |-> o_word_last)
        else $error("area_done without word_last");

    // Only written pixels carry a value.
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_pixel_action != ACT_WRITE)) |-> (o_pixel_value == '0))
        else $error("nonzero value on a non-write pixel");

    // A stalled receiver freezes the area position.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> ($stable(r_row) && $stable(r_col)
                                           && $stable(r_cursor)))
        else $error("area position moved during a stall");

    // Finishing an area returns the position to its origin.
    a_area_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (gen && area_end) |=> ((r_row == '0) && (r_col == '0) && (r_cursor == '0)))
        else $error("position not cleared after the final pixel");

endmodule

FILE: rtl/mceb_pixel_mode.sv
// ----------------------------------------------------------------------------
// Pixel mode decode
// Turns one source bit into a destination action and pixel value.
// ----------------------------------------------------------------------------
module mceb_pixel_mode (
    input  mceb_pkg::t_write_mode i_mode,
    input  logic                  i_bit,
    input  logic [15:0]           i_fg,
    input  logic [15:0]           i_bg,
    output logic [15:0]           o_value,
    output mceb_pkg::t_action     o_action
);
    import mceb_pkg::*;

    always_comb begin
        o_value  = '0;
        o_action = ACT_KEEP;
        unique case (i_mode)
            MODE_REPLACE: begin
                o_action = ACT_WRITE;
                o_value  = i_bit ? i_fg : i_bg;
            end
            MODE_TRANSPARENT: begin
                if (i_bit) begin
                    o_action = ACT_WRITE;
                    o_value  = i_fg;
                end
            end
            MODE_XOR: begin
                if (i_bit) begin
                    o_action = ACT_INVERT;
                end
            end
            MODE_REV_TRANS: begin
                if (!i_bit) begin
                    o_action = ACT_WRITE;
                    o_value  = i_fg;
                end
            end
        endcase
    end

endmodule
